// ===== hw/rtl/mtep_pkg.sv =====
// Shared types and constants for the MIDI track event parser.
package mtep_pkg;

	localparam int CHANNELS     = 16;
	localparam int KEYS         = 128;
	localparam int COUNTER_BITS = 16;

	// The key counters are stored as rows of LANES counters, one valid bit per row.
	localparam int LANES     = 8;
	localparam int LANE_BITS = $clog2(LANES);
	localparam int ROWS      = CHANNELS * KEYS / LANES;
	localparam int ROW_BITS  = $clog2(ROWS);

	typedef logic [COUNTER_BITS-1:0]       count_t;
	typedef logic [LANES*COUNTER_BITS-1:0] row_t;

	localparam count_t COUNT_MAX = '1;

	// Request from the parser to the key counter store.
	typedef struct packed {
		logic                 rd_en;
		logic [ROW_BITS-1:0]  rd_row;
		logic [LANE_BITS-1:0] rd_lane;
		logic                 wr_en;
		count_t               wr_count;
		logic                 clear;
	} key_req_t;

	// One result item.
	typedef struct packed {
		logic        event_done;
		logic [31:0] tick;
		logic [31:0] note_total;
		logic        tempo_valid;
		logic [23:0] tempo_value;
		logic        end_of_track;
		logic        unexpected_status;
		logic        length_error;
	} result_t;

endpackage

// ===== hw/rtl/mtep_key_store.sv =====
// Per-channel, per-key note counters held in a row memory with per-row valid bits.
module mtep_key_store import mtep_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  key_req_t req,
	output count_t   count
);

	row_t                 mem [ROWS];
	row_t                 rd_data_q;
	logic [ROW_BITS-1:0]  row_q;
	logic [LANE_BITS-1:0] lane_q;
	logic [ROWS-1:0]      row_valid_q;
	row_t                 base;
	row_t                 merged;

	// A row that was not written since the last clear reads as all zero.
	always_comb begin
		base   = row_valid_q[row_q] ? rd_data_q : '0;
		merged = base;
		merged[lane_q*COUNTER_BITS +: COUNTER_BITS] = req.wr_count;
		count  = base[lane_q*COUNTER_BITS +: COUNTER_BITS];
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_row];
			row_q     <= req.rd_row;
			lane_q    <= req.rd_lane;
		end
		if (req.wr_en) begin
			mem[row_q] <= merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (req.clear) begin
			row_valid_q <= '0;
		end else if (req.wr_en) begin
			row_valid_q[row_q] <= 1'b1;
		end
	end

endmodule

// ===== hw/rtl/mtep_parser.sv =====
// Byte-level track parser: phase, running status, varlen, tick, tempo and note counting.
module mtep_parser import mtep_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] byte_in,
	input  logic       start,
	input  count_t     count,
	output key_req_t   key_req,
	output result_t    res
);

	typedef enum logic [3:0] {
		PH_DELTA,
		PH_STATUS,
		PH_DATA1,
		PH_DATA2,
		PH_META_TYPE,
		PH_META_LEN,
		PH_TEMPO,
		PH_SKIP,
		PH_SYSEX_LEN
	} phase_t;

	localparam logic [7:0] ST_META      = 8'hFF;
	localparam logic [7:0] ST_SYSEX     = 8'd240;
	localparam logic [7:0] ST_SYSEX_ESC = 8'd247;
	localparam logic [7:0] ST_CHAN_LO   = 8'd128;
	localparam logic [7:0] ST_CHAN_HI   = 8'd239;
	localparam logic [7:0] ST_OFF_HI    = 8'd143;
	localparam logic [7:0] ST_ON_HI     = 8'd159;
	localparam logic [7:0] ST_CC_LO     = 8'd176;
	localparam logic [7:0] ST_CC_HI     = 8'd191;
	localparam logic [7:0] ST_ONE_LO    = 8'd192;
	localparam logic [7:0] ST_ONE_HI    = 8'd223;
	localparam logic [7:0] META_END     = 8'd47;
	localparam logic [7:0] META_TEMPO   = 8'd81;
	localparam logic [7:0] CC_MONO      = 8'd126;
	localparam logic [7:0] MONO_SWALLOW = 8'd4;

	phase_t      phase_q;
	logic [7:0]  rs_q;
	logic [27:0] va_q;
	logic [2:0]  vc_q;
	logic [31:0] tick_q;
	logic [31:0] notes_q;
	logic [7:0]  first_q;
	logic [7:0]  meta_q;
	logic [27:0] skip_q;
	logic [23:0] tempo_q;
	logic        ended_q;
	logic        mono_q;
	logic        bad_q;

	// State as seen after the track start clear.
	phase_t      c_phase;
	logic [27:0] c_va;
	logic [2:0]  c_vc;
	logic [31:0] c_tick;
	logic [27:0] c_skip;
	logic [23:0] c_tempo;
	logic        c_ended;
	logic        c_mono;

	phase_t      n_phase;
	logic [7:0]  n_rs;
	logic [27:0] n_va;
	logic [2:0]  n_vc;
	logic [31:0] n_tick;
	logic [31:0] n_notes;
	logic [7:0]  n_first;
	logic [7:0]  n_meta;
	logic [27:0] n_skip;
	logic [23:0] n_tempo;
	logic        n_ended;
	logic        n_mono;
	logic        n_bad;

	logic [27:0] fb_acc;
	logic [2:0]  fb_cnt;
	logic        fb_done;
	logic [32:0] tick_sum;
	logic [23:0] tempo_new;
	logic [2:0]  tempo_cnt;
	logic [7:0]  st;
	logic        reuse;
	logic        swallowed;
	logic        ev;
	logic        tv;
	logic        lerr;
	logic        key_ok;
	logic        rd_en;
	logic        wr_en;
	count_t      wr_count;

	assign c_phase = start ? PH_DELTA : phase_q;
	assign c_va    = start ? '0 : va_q;
	assign c_vc    = start ? '0 : vc_q;
	assign c_tick  = start ? '0 : tick_q;
	assign c_skip  = start ? '0 : skip_q;
	assign c_tempo = start ? '0 : tempo_q;
	assign c_ended = start ? 1'b0 : ended_q;
	assign c_mono  = start ? 1'b0 : mono_q;

	// Variable-length decoder step: seven bits a byte, four bytes at most.
	assign fb_acc   = {c_va[20:0], byte_in[6:0]};
	assign fb_cnt   = c_vc + 3'd1;
	assign fb_done  = !byte_in[7] || (fb_cnt >= 3'd4);
	assign tick_sum = {1'b0, c_tick} + {5'b0, fb_acc};

	assign tempo_new = {c_tempo[15:0], byte_in};
	assign tempo_cnt = c_vc + 3'd1;

	assign reuse  = !byte_in[7];
	assign st     = reuse ? rs_q : byte_in;
	assign key_ok = !first_q[7];

	always_comb begin
		n_phase  = c_phase;
		n_rs     = rs_q;
		n_va     = c_va;
		n_vc     = c_vc;
		n_tick   = c_tick;
		n_notes  = notes_q;
		n_first  = first_q;
		n_meta   = meta_q;
		n_skip   = c_skip;
		n_tempo  = c_tempo;
		n_ended  = c_ended;
		n_mono   = c_mono;
		n_bad    = bad_q;
		swallowed = 1'b0;
		ev       = 1'b0;
		tv       = 1'b0;
		lerr     = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		wr_count = count;

		// After a mono mode controller, a following value of four is dropped.
		if (!c_ended && c_mono) begin
			n_mono = 1'b0;
			if (byte_in == MONO_SWALLOW) begin
				swallowed = 1'b1;
			end
		end

		if (!c_ended && !swallowed) begin
			case (c_phase)
				PH_DELTA: begin
					n_va = fb_acc;
					n_vc = fb_cnt;
					if (fb_done) begin
						lerr    = byte_in[7];
						n_va    = '0;
						n_vc    = '0;
						n_tick  = tick_sum[32] ? '1 : tick_sum[31:0];
						n_phase = PH_STATUS;
					end
				end
				PH_STATUS: begin
					n_rs = st;
					n_va = '0;
					n_vc = '0;
					if (st == ST_META) begin
						if (reuse) begin
							n_meta  = byte_in;
							n_phase = PH_META_LEN;
						end else begin
							n_phase = PH_META_TYPE;
						end
					end else if (st >= ST_CHAN_LO && st <= ST_CHAN_HI) begin
						if (reuse) begin
							// The byte is the first data byte of a running-status event.
							n_first = byte_in;
							rd_en   = 1'b1;
							if (st >= ST_ONE_LO && st <= ST_ONE_HI) begin
								ev      = 1'b1;
								n_phase = PH_DELTA;
							end else begin
								n_phase = PH_DATA2;
							end
						end else begin
							n_phase = PH_DATA1;
						end
					end else if (st == ST_SYSEX || st == ST_SYSEX_ESC) begin
						if (reuse) begin
							// A one-byte length, fed from a cleared decoder.
							if (byte_in[6:0] == 7'd0) begin
								ev      = 1'b1;
								n_phase = PH_DELTA;
							end else begin
								n_skip  = {21'd0, byte_in[6:0]};
								n_phase = PH_SKIP;
							end
						end else begin
							n_phase = PH_SYSEX_LEN;
						end
					end else begin
						ev      = 1'b1;
						n_phase = PH_DELTA;
					end
				end
				PH_DATA1: begin
					n_first = byte_in;
					rd_en   = 1'b1;
					if (byte_in[7]) begin
						n_bad = 1'b1;
					end
					if (rs_q >= ST_ONE_LO && rs_q <= ST_ONE_HI) begin
						ev      = 1'b1;
						n_phase = PH_DELTA;
					end else begin
						n_phase = PH_DATA2;
					end
				end
				PH_DATA2: begin
					if (byte_in[7]) begin
						n_bad = 1'b1;
					end
					if (rs_q <= ST_OFF_HI || (rs_q <= ST_ON_HI && byte_in == 8'd0)) begin
						if (key_ok && count != '0) begin
							wr_en    = 1'b1;
							wr_count = count - count_t'(1);
							if (notes_q != '1) begin
								n_notes = notes_q + 32'd1;
							end
						end
					end else if (rs_q <= ST_ON_HI) begin
						if (key_ok && count != COUNT_MAX) begin
							wr_en    = 1'b1;
							wr_count = count + count_t'(1);
						end
					end else if (rs_q >= ST_CC_LO && rs_q <= ST_CC_HI &&
					             first_q == CC_MONO && byte_in == 8'd0) begin
						n_mono = 1'b1;
					end
					ev      = 1'b1;
					n_phase = PH_DELTA;
				end
				PH_META_TYPE: begin
					n_meta  = byte_in;
					n_va    = '0;
					n_vc    = '0;
					n_phase = PH_META_LEN;
				end
				PH_META_LEN: begin
					n_va = fb_acc;
					n_vc = fb_cnt;
					if (fb_done) begin
						lerr = byte_in[7];
						n_va = '0;
						n_vc = '0;
						if (meta_q == META_END) begin
							n_ended = 1'b1;
							ev      = 1'b1;
							n_phase = PH_DELTA;
						end else if (meta_q == META_TEMPO) begin
							n_tempo = '0;
							n_phase = PH_TEMPO;
						end else if (fb_acc == '0) begin
							ev      = 1'b1;
							n_phase = PH_DELTA;
						end else begin
							n_skip  = fb_acc;
							n_phase = PH_SKIP;
						end
					end
				end
				PH_TEMPO: begin
					n_tempo = tempo_new;
					n_vc    = tempo_cnt;
					if (tempo_cnt >= 3'd3) begin
						n_vc    = '0;
						tv      = 1'b1;
						ev      = 1'b1;
						n_phase = PH_DELTA;
					end
				end
				PH_SKIP: begin
					if (c_skip <= 28'd1) begin
						n_skip  = '0;
						ev      = 1'b1;
						n_phase = PH_DELTA;
					end else begin
						n_skip = c_skip - 28'd1;
					end
				end
				PH_SYSEX_LEN: begin
					n_va = fb_acc;
					n_vc = fb_cnt;
					if (fb_done) begin
						lerr = byte_in[7];
						n_va = '0;
						n_vc = '0;
						if (fb_acc == '0) begin
							ev      = 1'b1;
							n_phase = PH_DELTA;
						end else begin
							n_skip  = fb_acc;
							n_phase = PH_SKIP;
						end
					end
				end
				default: begin
					n_phase = PH_DELTA;
				end
			endcase
		end
	end

	// Counter row and lane follow from the channel of running status and the key.
	always_comb begin
		key_req.rd_en    = fire && rd_en;
		key_req.rd_row   = {rs_q[3:0], byte_in[6:LANE_BITS]};
		key_req.rd_lane  = byte_in[LANE_BITS-1:0];
		key_req.wr_en    = fire && wr_en;
		key_req.wr_count = wr_count;
		key_req.clear    = fire && start;
	end

	always_comb begin
		res.event_done        = ev;
		res.tick              = n_tick;
		res.note_total        = n_notes;
		res.tempo_valid       = tv;
		res.tempo_value       = tv ? tempo_new : '0;
		res.end_of_track      = n_ended;
		res.unexpected_status = n_bad;
		res.length_error      = lerr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DELTA;
			rs_q    <= '0;
			va_q    <= '0;
			vc_q    <= '0;
			tick_q  <= '0;
			notes_q <= '0;
			first_q <= '0;
			meta_q  <= '0;
			skip_q  <= '0;
			tempo_q <= '0;
			ended_q <= 1'b0;
			mono_q  <= 1'b0;
			bad_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= n_phase;
			rs_q    <= n_rs;
			va_q    <= n_va;
			vc_q    <= n_vc;
			tick_q  <= n_tick;
			notes_q <= n_notes;
			first_q <= n_first;
			meta_q  <= n_meta;
			skip_q  <= n_skip;
			tempo_q <= n_tempo;
			ended_q <= n_ended;
			mono_q  <= n_mono;
			bad_q   <= n_bad;
		end
	end

endmodule

// ===== hw/rtl/midi_track_event_parser_unit.sv =====
// Top level of the MIDI track event parser: input stage, parser, key store, result stage.
//
// The block takes the event bytes of a MIDI track, one byte per item, and returns one
// result item per byte. It sustains one item per clock cycle while out_ready does not
// hold the output back: the byte is captured in an input stage, parsed in one pass of
// combinational logic, and the result is held in an output register, so a new item is
// taken while an earlier result waits. The note counters (16 channels by 128 keys) live
// in a memory of 256 rows of eight counters; the row is read through its registered port
// when the first data byte of a channel message passes the parser and is updated when
// the second data byte passes, which is always at least one item later. Each row has a
// valid bit, and a byte with track_start clears all of them at once, so the counters
// start each track at zero with no clearing pass and no stall after reset.
module midi_track_event_parser_unit import mtep_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        track_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        event_done,
	output logic [31:0] tick,
	output logic [31:0] note_total,
	output logic        tempo_valid,
	output logic [23:0] tempo_value,
	output logic        end_of_track,
	output logic        unexpected_status,
	output logic        length_error
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       valid_s2;
	result_t    res_s2;

	result_t    res;
	key_req_t   key_req;
	count_t     count;
	logic       adv;
	logic       in_acc;

	// The input stage moves into the result stage whenever the result stage is empty
	// or its item is being taken in the same cycle.
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			res_s2   <= '0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
				res_s2   <= res;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1  <= data_byte;
			start_s1 <= track_start;
		end
	end

	mtep_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (adv),
		.byte_in (byte_s1),
		.start   (start_s1),
		.count   (count),
		.key_req (key_req),
		.res     (res)
	);

	mtep_key_store u_key_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (key_req),
		.count  (count)
	);

	assign out_valid         = valid_s2;
	assign event_done        = res_s2.event_done;
	assign tick              = res_s2.tick;
	assign note_total        = res_s2.note_total;
	assign tempo_valid       = res_s2.tempo_valid;
	assign tempo_value       = res_s2.tempo_value;
	assign end_of_track      = res_s2.end_of_track;
	assign unexpected_status = res_s2.unexpected_status;
	assign length_error      = res_s2.length_error;

`ifndef SYNTHESIS
	// Within a track the tick count never goes backwards.
	a_tick_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !start_s1 |=> res_s2.tick >= $past(res_s2.tick))
		else $error("tick decreased within a track");

	// The completed note count grows by at most one per item.
	a_notes_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (res_s2.note_total == $past(res_s2.note_total)) ||
		        (res_s2.note_total == $past(res_s2.note_total) + 32'd1))
		else $error("note total changed by more than one");

	// The input side may only stall while both stages hold an item.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 || !valid_s2 || out_ready |-> in_ready)
		else $error("input stalled with room in the pipeline");

	// A counter write never coincides with a row read or a clear.
	a_write_not_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		key_req.wr_en |-> !key_req.clear && !key_req.rd_en)
		else $error("counter write collided with read or clear");
`endif

endmodule
